// ===== rtl/core/lsf_pkg.sv =====
// shared types and constants of the least-squares line fit
`default_nettype none

package lsf_pkg;

   // operations of the shared arithmetic unit
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

   // width of one coordinate and of one fitted value
   localparam int COORD_W = 16;
   localparam int FIT_W   = 32;

   // command from the sequencer to the shared unit
   typedef struct packed {
      logic start;
      logic op;
   } lsf_cmd_type;

   // status from the shared unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } lsf_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/lsf_shared_unit.sv =====
// shared shift-add multiplier and restoring divider on one adder
`default_nettype none

module lsf_shared_unit #(
   parameter int WW = 61,
   parameter int DW = 77
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lsf_pkg::lsf_cmd_type cmd,
   input  logic [DW-1:0]        opa,
   input  logic [WW-1:0]        opb,
   output lsf_pkg::lsf_stat_type stat,
   output logic [DW-1:0]        result
);
   import lsf_pkg::*;

   localparam int CNTW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            op_ff, op_in;
   logic [DW-1:0]   acc_ff, acc_in;
   logic [DW-1:0]   a_ff, a_in;
   logic [WW-1:0]   b_ff, b_in;
   logic [WW-1:0]   rem_ff, rem_in;

   logic [WW:0]     rem_sh;
   logic [DW:0]     add_x;
   logic [DW:0]     add_y;
   logic            add_sub;
   logic [DW:0]     add_sum;

   // the one adder: accumulate for multiply, trial subtract for divide
   assign rem_sh = {rem_ff, acc_ff[DW-1]};

   always_comb begin
      if (op_ff == OP_DIV) begin
         add_x   = {{(DW - WW){1'b0}}, rem_sh};
         add_y   = {{(DW + 1 - WW){1'b0}}, b_ff};
         add_sub = 1'b1;
      end else begin
         add_x   = {1'b0, acc_ff};
         add_y   = {1'b0, a_ff};
         add_sub = 1'b0;
      end
      add_sum = add_x + (add_sub ? ~add_y : add_y) + {{DW{1'b0}}, add_sub};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = (cmd.op == OP_DIV) ? CNTW'(DW) : CNTW'(WW);
         acc_in  = (cmd.op == OP_DIV) ? opa : '0;
         a_in    = opa;
         b_in    = opb;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == OP_DIV) begin
            // no borrow: divisor fits, quotient bit is one
            if (!add_sum[DW]) begin
               rem_in = add_sum[WW-1:0];
               acc_in = {acc_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[WW-1:0];
               acc_in = {acc_ff[DW-2:0], 1'b0};
            end
         end else begin
            if (b_ff[0]) begin
               acc_in = add_sum[DW-1:0];
            end
            a_in = {a_ff[DW-2:0], 1'b0};
            b_in = {1'b0, b_ff[WW-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("shared unit started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("shared unit done held longer than one cycle");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("shared unit busy with no iterations left");

endmodule

`default_nettype wire

// ===== rtl/core/least_squares_line_fit.sv =====
// least-squares straight-line fit over sets of Q8.8 points, Q16.16 results
//
//   channel | dir | ports                                        | transfer when
//   --------+-----+----------------------------------------------+-----------------------
//   req     | in  | req_sample_x, req_sample_y, req_last_point   | req_valid & !req_stall
//   rsp     | out | rsp_slope, rsp_intercept, rsp_status         | rsp_valid & !rsp_stall
//
// a point: one 16x16 multiplier forms x*y in the transfer cycle, x*x next, while req stalls
// a closing point adds the fit: 5 shift-add multiplies and 2 restoring divides on the shared
//   unit, one at a time
// reset is synchronous and clears the running sums, the count and rsp_valid; no sweep
// a finished result waits in the output register while the next set's points transfer;
// a fit that ends while that register is still full holds until it is taken
`default_nettype none

module least_squares_line_fit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [lsf_pkg::COORD_W-1:0]    req_sample_x,
   input  logic signed [lsf_pkg::COORD_W-1:0]    req_sample_y,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lsf_pkg::FIT_W-1:0]      rsp_slope,
   output logic signed [lsf_pkg::FIT_W-1:0]      rsp_intercept,
   output logic [1:0]                            rsp_status
);
   import lsf_pkg::*;

   // widths follow from the largest set
   localparam int CW   = $clog2(MAX_POINTS + 1);   // point count
   localparam int SXW  = COORD_W + CW;             // sum of x or y, signed
   localparam int SXYW = 2 * COORD_W + CW;         // sum of x*y, signed
   localparam int SXXW = 2 * COORD_W - 2 + CW;     // sum of x*x, unsigned
   localparam int WW   = SXW + 34;                 // fit terms, signed
   localparam int DW   = WW + 16;                  // dividends and quotients

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQR    = 3'd1;
   localparam logic [2:0] S_LAUNCH = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   // fit steps, each one operation on the shared unit
   localparam logic [2:0] STEP_NXX   = 3'd0;   // n * sum xx
   localparam logic [2:0] STEP_SXSX  = 3'd1;   // sum x squared, gives denominator
   localparam logic [2:0] STEP_NXY   = 3'd2;   // n * sum xy
   localparam logic [2:0] STEP_SXSY  = 3'd3;   // sum x * sum y, gives numerator
   localparam logic [2:0] STEP_SLOPE = 3'd4;   // numerator * 2^16 / denominator
   localparam logic [2:0] STEP_QX    = 3'd5;   // slope * sum x
   localparam logic [2:0] STEP_ICPT  = 3'd6;   // intercept numerator / (256 n)

   logic [2:0]          state_ff, state_in;
   logic [2:0]          step_ff, step_in;

   // running set state
   logic [CW-1:0]       count_ff, count_in;
   logic [SXW-1:0]      sx_ff, sx_in;
   logic [SXW-1:0]      sy_ff, sy_in;
   logic [SXYW-1:0]     sxy_ff, sxy_in;
   logic [SXXW-1:0]     sxx_ff, sxx_in;
   logic                ovf_ff, ovf_in;

   // point held for the x*x cycle
   logic [COORD_W-1:0]  x_ff, x_in;
   logic                last_ff, last_in;
   logic                take_ff, take_in;

   // fit working registers
   logic [WW-1:0]       t_ff, t_in;
   logic [WW-1:0]       den_ff, den_in;
   logic [FIT_W-1:0]    slope_ff, slope_in;
   logic [FIT_W-1:0]    icpt_ff, icpt_in;
   logic [1:0]          status_ff, status_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIT_W-1:0]    rsp_slope_ff, rsp_slope_in;
   logic [FIT_W-1:0]    rsp_icpt_ff, rsp_icpt_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                req_take;
   logic                set_full;
   logic                out_free;

   logic signed [COORD_W-1:0]   mul_x;
   logic signed [COORD_W-1:0]   mul_y;
   logic signed [2*COORD_W-1:0] pt_prod;

   logic                sx_neg, sy_neg, sxy_neg, t_neg, slope_neg;
   logic [SXW-1:0]      sx_mag, sy_mag;
   logic [SXYW-1:0]     sxy_mag;
   logic [WW-1:0]       t_mag;
   logic [FIT_W:0]      slope_mag;

   lsf_cmd_type         unit_cmd;
   lsf_stat_type        unit_stat;
   logic                launch_op;
   logic [DW-1:0]       unit_opa;
   logic [WW-1:0]       unit_opb;
   logic [DW-1:0]       unit_result;
   logic [WW-1:0]       prod;

   logic [WW-1:0]       post_a;
   logic [WW-1:0]       post_b;
   logic                post_sub;
   logic [WW-1:0]       post_sum;

   // truncated quotient to Q16.16 with saturation
   function automatic logic [FIT_W-1:0] sat_fit(input logic neg, input logic [DW-1:0] q);
      logic [FIT_W-1:0] r;
      if (neg) begin
         if (q > DW'(32'h8000_0000)) begin
            r = 32'h8000_0000;
         end else begin
            r = ~q[FIT_W-1:0] + 1'b1;
         end
      end else begin
         if (q > DW'(32'h7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
         end else begin
            r = q[FIT_W-1:0];
         end
      end
      return r;
   endfunction

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign set_full  = (count_ff >= CW'(MAX_POINTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // one point multiplier: x*y from the ports at transfer, x*x from the held point
   assign mul_x   = (state_ff == S_IDLE) ? req_sample_x : $signed(x_ff);
   assign mul_y   = (state_ff == S_IDLE) ? req_sample_y : $signed(x_ff);
   assign pt_prod = mul_x * mul_y;

   // magnitudes fed to the unsigned shared unit
   assign sx_neg    = sx_ff[SXW-1];
   assign sy_neg    = sy_ff[SXW-1];
   assign sxy_neg   = sxy_ff[SXYW-1];
   assign t_neg     = t_ff[WW-1];
   assign slope_neg = slope_ff[FIT_W-1];
   assign sx_mag    = sx_neg ? (~sx_ff + 1'b1) : sx_ff;
   assign sy_mag    = sy_neg ? (~sy_ff + 1'b1) : sy_ff;
   assign sxy_mag   = sxy_neg ? (~sxy_ff + 1'b1) : sxy_ff;
   assign t_mag     = t_neg ? (~t_ff + 1'b1) : t_ff;
   assign slope_mag = slope_neg ? (~{slope_ff[FIT_W-1], slope_ff} + 1'b1)
                                : {1'b0, slope_ff};

   // operands of each fit step
   always_comb begin
      launch_op = OP_MUL;
      unit_opa  = '0;
      unit_opb  = '0;
      case (step_ff)
         STEP_NXX: begin
            unit_opa = {{(DW - CW){1'b0}}, count_ff};
            unit_opb = {{(WW - SXXW){1'b0}}, sxx_ff};
         end
         STEP_SXSX: begin
            unit_opa = {{(DW - SXW){1'b0}}, sx_mag};
            unit_opb = {{(WW - SXW){1'b0}}, sx_mag};
         end
         STEP_NXY: begin
            unit_opa = {{(DW - CW){1'b0}}, count_ff};
            unit_opb = {{(WW - SXYW){1'b0}}, sxy_mag};
         end
         STEP_SXSY: begin
            unit_opa = {{(DW - SXW){1'b0}}, sx_mag};
            unit_opb = {{(WW - SXW){1'b0}}, sy_mag};
         end
         STEP_SLOPE: begin
            launch_op = OP_DIV;
            unit_opa  = {t_mag, 16'h0000};
            unit_opb  = den_ff;
         end
         STEP_QX: begin
            unit_opa = {{(DW - FIT_W - 1){1'b0}}, slope_mag};
            unit_opb = {{(WW - SXW){1'b0}}, sx_mag};
         end
         STEP_ICPT: begin
            // dividing by 256 n: drop eight bits, then divide by n
            launch_op = OP_DIV;
            unit_opa  = {{(DW - WW + 8){1'b0}}, t_mag[WW-1:8]};
            unit_opb  = {{(WW - CW){1'b0}}, count_ff};
         end
         default: begin
            launch_op = OP_MUL;
         end
      endcase
   end

   // one post adder folds each product into the running fit term
   assign prod = unit_result[WW-1:0];

   always_comb begin
      post_a   = '0;
      post_sub = 1'b0;
      case (step_ff)
         STEP_SXSX: begin
            post_a   = t_ff;
            post_sub = 1'b1;
         end
         STEP_NXY: begin
            post_sub = sxy_neg;
         end
         STEP_SXSY: begin
            post_a   = t_ff;
            post_sub = !(sx_neg ^ sy_neg);
         end
         STEP_QX: begin
            // sum y in Q.24 less the signed product
            post_a   = {{(WW - SXW - 16){sy_neg}}, sy_ff, 16'h0000};
            post_sub = !(slope_neg ^ sx_neg);
         end
         default: begin
            post_sub = 1'b0;
         end
      endcase
      post_b   = prod;
      post_sum = post_a + (post_sub ? ~post_b : post_b) + {{(WW - 1){1'b0}}, post_sub};
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sxy_in        = sxy_ff;
      sxx_in        = sxx_ff;
      ovf_in        = ovf_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      take_in       = take_ff;
      t_in          = t_ff;
      den_in        = den_ff;
      slope_in      = slope_ff;
      icpt_in       = icpt_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_status_in = rsp_status_ff;
      unit_cmd      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               x_in    = req_sample_x;
               last_in = req_last_point;
               if (set_full) begin
                  // points beyond the limit are dropped and flag the set
                  ovf_in  = 1'b1;
                  take_in = 1'b0;
               end else begin
                  take_in  = 1'b1;
                  count_in = count_ff + 1'b1;
                  sx_in    = sx_ff + {{CW{req_sample_x[COORD_W-1]}}, req_sample_x};
                  sy_in    = sy_ff + {{CW{req_sample_y[COORD_W-1]}}, req_sample_y};
                  sxy_in   = sxy_ff + {{CW{pt_prod[2*COORD_W-1]}}, pt_prod};
               end
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            if (take_ff) begin
               sxx_in = sxx_ff + {{(SXXW - 2*COORD_W + 1){1'b0}}, pt_prod[2*COORD_W-2:0]};
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (ovf_ff) begin
               slope_in  = '0;
               icpt_in   = '0;
               status_in = STATUS_TOO_MANY;
               state_in  = S_OUT;
            end else begin
               step_in  = STEP_NXX;
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            unit_cmd.start = 1'b1;
            unit_cmd.op    = launch_op;
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            if (unit_stat.done) begin
               step_in  = step_ff + 3'd1;
               state_in = S_LAUNCH;
               case (step_ff)
                  STEP_NXX, STEP_NXY, STEP_SXSY, STEP_QX: begin
                     t_in = post_sum;
                  end
                  STEP_SXSX: begin
                     den_in = post_sum;
                     // single point or all x equal
                     if (post_sum == '0) begin
                        slope_in  = '0;
                        icpt_in   = '0;
                        status_in = STATUS_ZERO_DEN;
                        state_in  = S_OUT;
                     end
                  end
                  STEP_SLOPE: begin
                     slope_in = sat_fit(t_neg, unit_result);
                  end
                  STEP_ICPT: begin
                     icpt_in   = sat_fit(t_neg, unit_result);
                     status_in = STATUS_OK;
                     state_in  = S_OUT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slope_in  = slope_ff;
               rsp_icpt_in   = icpt_ff;
               rsp_status_in = status_ff;
               // the set is closed: start the next one empty
               count_in      = '0;
               sx_in         = '0;
               sy_in         = '0;
               sxy_in        = '0;
               sxx_in        = '0;
               ovf_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_NXX;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxy_ff       <= '0;
         sxx_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxy_ff       <= sxy_in;
         sxx_ff       <= sxx_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      last_ff       <= last_in;
      take_ff       <= take_in;
      t_ff          <= t_in;
      den_ff        <= den_in;
      slope_ff      <= slope_in;
      icpt_ff       <= icpt_in;
      status_ff     <= status_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_status_ff <= rsp_status_in;
   end

   lsf_shared_unit #(
      .WW (WW),
      .DW (DW)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opa    (unit_opa),
      .opb    (unit_opb),
      .stat   (unit_stat),
      .result (unit_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slope     = $signed(rsp_slope_ff);
   assign rsp_intercept = $signed(rsp_icpt_ff);
   assign rsp_status    = rsp_status_ff;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond the set limit");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> (state_ff == S_WAIT))
      else $error("shared unit finished outside the wait state");

   a_divide_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAUNCH && step_ff == STEP_SLOPE) |-> (den_ff != '0))
      else $error("slope divide launched with zero denominator");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (count_ff == '0 && !ovf_ff && rsp_valid_ff))
      else $error("set not cleared when its result was loaded");

endmodule

`default_nettype wire
